[design/lts_pkg.sv]
// lts_pkg: types and constants shared by the loop token sequencer
// request and response structs, function and status codes, controller states
// no dependencies
`default_nettype none

package lts_pkg;

  localparam int TOKEN_W   = 8;
  localparam int VALUE_W   = 32;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int TGT_W     = VALUE_W + 1;
  localparam int CFG_IDX_W = 1;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_MATCH  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FETCH  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REWIND = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNMATCHED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 1'b1;

  localparam logic [TOKEN_W-1:0] BEGIN_CODE_RESET = 8'd1;
  localparam logic [TOKEN_W-1:0] END_CODE_RESET   = 8'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [TOKEN_W-1:0]        token_code;
    logic signed [VALUE_W-1:0] token_value;
    logic                      cond_valid;
  } req_t;

  typedef struct packed {
    logic [TOKEN_W-1:0]        token_out;
    logic signed [VALUE_W-1:0] value_out;
    logic [STATUS_W-1:0]       status;
    logic                      stream_end;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH_RD,
    S_FETCH_JMP,
    S_MATCH_RD,
    S_MATCH_EX,
    S_MATCH_POP,
    S_MATCH_WR,
    S_PUSH
  } state_t;

endpackage

`default_nettype wire

[design/loop_token_sequencer_core.sv]
// loop_token_sequencer_core: token program store with loop matching and fetch
// depends on lts_pkg; checker attached by bind in lts_checker.sv
`default_nettype none

// One request is taken at a time; the response sits in an output register so the
// next request can be taken while it waits. Append, rewind, clear and unused
// functions go straight to the response state. So does a fetch that starts at
// end of stream; an ordinary token, or a loop token whose jump leaves the stream,
// is answered from one read, and a loop token that makes it jump reads again at
// the target, since the jump target comes from the registered read of the value
// memory. The match pass walks the stored tokens through the single read port of
// the token memory, reading then examining each one; an end token also takes a
// stack memory read, then two value writes on the one write port.
// Token, value and stack memories are not cleared at reset and need no clearing
// pass: only entries written since the last clear are ever read.
module loop_token_sequencer_core
  import lts_pkg::*;
#(
  parameter int MAX_TOKENS  = 1024,
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire req_t                 req_data,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output rsp_t                      rsp_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TOKEN_W-1:0]   cfg_data
);

  localparam int PW  = $clog2(MAX_TOKENS);
  localparam int CW  = $clog2(MAX_TOKENS + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  // memories
  logic [TOKEN_W-1:0] token_mem [MAX_TOKENS];
  logic [VALUE_W-1:0] value_mem [MAX_TOKENS];
  logic [PW-1:0]      stack_mem [STACK_DEPTH];

  state_t state, state_next;

  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      rp, rp_next;
  logic [CW-1:0]      idx, idx_next;
  logic [SPW-1:0]     sp, sp_next;
  logic               cond, cond_next;
  rsp_t               res, res_next;
  logic [TOKEN_W-1:0] begin_code, end_code;

  logic               mem_re;
  logic [PW-1:0]      mem_raddr;
  logic [TOKEN_W-1:0] tok_rdata;
  logic [VALUE_W-1:0] val_rdata;
  logic               tok_we;
  logic               val_we;
  logic [PW-1:0]      val_waddr;
  logic [VALUE_W-1:0] val_wdata;

  logic               stk_we, stk_re;
  logic [SAW-1:0]     stk_waddr, stk_raddr;
  logic [PW-1:0]      stk_rdata;

  logic               accept;
  logic               rsp_load;
  logic               is_begin, is_end;
  logic [TGT_W-1:0]   rp_ext, count_ext, tgt;
  logic [SPW-1:0]     sp_dec;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_load  = (state == S_PUSH) && (!rsp_valid || !rsp_stall);

  assign is_begin  = (tok_rdata == begin_code);
  assign is_end    = !is_begin && (tok_rdata == end_code);
  assign rp_ext    = {{(TGT_W-CW){1'b0}}, rp};
  assign count_ext = {{(TGT_W-CW){1'b0}}, count};
  assign sp_dec    = sp - SPW'(1);

  // jump target of a fetch, from the token and value read at rp
  always_comb begin
    if (is_begin) begin
      tgt = cond ? rp_ext + TGT_W'(1) : {1'b0, val_rdata};
    end else if (is_end) begin
      tgt = cond ? {1'b0, val_rdata} + TGT_W'(1) : rp_ext + TGT_W'(1);
    end else begin
      tgt = rp_ext;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    rp_next    = rp;
    idx_next   = idx;
    sp_next    = sp;
    cond_next  = cond;
    res_next   = res;
    mem_re     = 1'b0;
    mem_raddr  = rp[PW-1:0];
    tok_we     = 1'b0;
    val_we     = 1'b0;
    val_waddr  = count[PW-1:0];
    val_wdata  = req_data.token_value;
    stk_we     = 1'b0;
    stk_waddr  = sp[SAW-1:0];
    stk_re     = 1'b0;
    stk_raddr  = sp_dec[SAW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_next   = '0;
          state_next = S_PUSH;
          case (req_data.func)
            FUNC_APPEND: begin
              if (count == CW'(MAX_TOKENS)) begin
                res_next.status = STATUS_FULL;
              end else begin
                tok_we     = 1'b1;
                val_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            FUNC_MATCH: begin
              sp_next    = '0;
              idx_next   = '0;
              state_next = S_MATCH_RD;
            end
            FUNC_FETCH: begin
              cond_next = req_data.cond_valid;
              if (rp >= count) begin
                res_next.stream_end = 1'b1;
              end else begin
                mem_re     = 1'b1;
                state_next = S_FETCH_RD;
              end
            end
            FUNC_REWIND: begin
              rp_next = '0;
            end
            FUNC_CLEAR: begin
              rp_next    = '0;
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_FETCH_RD: begin
        if (!is_begin && !is_end) begin
          res_next.token_out = tok_rdata;
          res_next.value_out = signed'(val_rdata);
          rp_next            = rp + CW'(1);
          state_next         = S_PUSH;
        end else if (tgt >= count_ext) begin
          rp_next             = count;
          res_next.stream_end = 1'b1;
          state_next          = S_PUSH;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = tgt[PW-1:0];
          rp_next    = tgt[CW-1:0];
          state_next = S_FETCH_JMP;
        end
      end

      S_FETCH_JMP: begin
        res_next.token_out = tok_rdata;
        res_next.value_out = signed'(val_rdata);
        rp_next            = rp + CW'(1);
        state_next         = S_PUSH;
      end

      S_MATCH_RD: begin
        if (idx >= count) begin
          state_next = S_PUSH;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = idx[PW-1:0];
          state_next = S_MATCH_EX;
        end
      end

      S_MATCH_EX: begin
        if (is_begin) begin
          if (sp == SPW'(STACK_DEPTH)) begin
            res_next.status = STATUS_OVERFLOW;
            state_next      = S_PUSH;
          end else begin
            stk_we     = 1'b1;
            sp_next    = sp + SPW'(1);
            idx_next   = idx + CW'(1);
            state_next = S_MATCH_RD;
          end
        end else if (is_end) begin
          if (sp == '0) begin
            res_next.status = STATUS_UNMATCHED;
            state_next      = S_PUSH;
          end else begin
            stk_re     = 1'b1;
            sp_next    = sp_dec;
            state_next = S_MATCH_POP;
          end
        end else begin
          idx_next   = idx + CW'(1);
          state_next = S_MATCH_RD;
        end
      end

      // patch the begin with the index after its end
      S_MATCH_POP: begin
        val_we     = 1'b1;
        val_waddr  = stk_rdata;
        val_wdata  = VALUE_W'(idx) + VALUE_W'(1);
        state_next = S_MATCH_WR;
      end

      // patch the end with the index of its begin
      S_MATCH_WR: begin
        val_we     = 1'b1;
        val_waddr  = idx[PW-1:0];
        val_wdata  = VALUE_W'(stk_rdata);
        idx_next   = idx + CW'(1);
        state_next = S_MATCH_RD;
      end

      S_PUSH: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rp         <= '0;
      idx        <= '0;
      sp         <= '0;
      rsp_valid  <= 1'b0;
      begin_code <= BEGIN_CODE_RESET;
      end_code   <= END_CODE_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      rp    <= rp_next;
      idx   <= idx_next;
      sp    <= sp_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BEGIN_CODE: begin_code <= cfg_data;
          CFG_END_CODE:   end_code   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cond <= cond_next;
    res  <= res_next;
    if (rsp_load) begin
      rsp_data <= res;
    end
  end

  // token memory: append writes, shared read port
  always_ff @(posedge clk) begin
    if (tok_we) begin
      token_mem[count[PW-1:0]] <= req_data.token_code;
    end
    if (mem_re) begin
      tok_rdata <= token_mem[mem_raddr];
    end
  end

  // value memory: append and match patches write, same read address as tokens
  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_waddr] <= val_wdata;
    end
    if (mem_re) begin
      val_rdata <= value_mem[mem_raddr];
    end
  end

  // begin stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= idx[PW-1:0];
    end
    if (stk_re) begin
      stk_rdata <= stack_mem[stk_raddr];
    end
  end

endmodule

`default_nettype wire

[design/lts_checker.sv]
// lts_checker: port-level checks for loop_token_sequencer_core
// depends on lts_pkg; bound to loop_token_sequencer_core at the end of this file
`default_nettype none

module lts_checker
  import lts_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp_data
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // one request at a time: busy in the cycle after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

  // end of stream carries no token and no error
  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.stream_end |->
      rsp_data.token_out == '0 && rsp_data.value_out == '0 &&
      rsp_data.status == STATUS_OK)
    else $error("end of stream response not clean");

  // an error response never carries fetch data
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != STATUS_OK |->
      !rsp_data.stream_end && rsp_data.token_out == '0 && rsp_data.value_out == '0)
    else $error("error response carries fetch data");

endmodule

bind loop_token_sequencer_core lts_checker u_lts_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

`default_nettype wire

[tb/sv/testbench.sv]
// testbench for loop_token_sequencer_core: directed and random requests, scoreboard check
// depends on lts_pkg and the core; predicts every response in a small scoreboard class
`timescale 1ns / 1ps

module testbench;
  import lts_pkg::*;

  localparam int MAX_TOKENS  = 1024;
  localparam int STACK_DEPTH = 64;
  localparam logic [FUNC_W-1:0] FUNC_FIRST_UNUSED = 3'd5;
  localparam int HOLD_CYCLES = 300;

  class loop_sequencer_board;
    logic [TOKEN_W-1:0] begin_code;
    logic [TOKEN_W-1:0] end_code;
    logic [TOKEN_W-1:0] tok_mem[MAX_TOKENS];
    logic [VALUE_W-1:0] val_mem[MAX_TOKENS];
    int unsigned        loop_stack[STACK_DEPTH];
    int unsigned        tok_count;
    int unsigned        rd_pos;
    rsp_t               results_due[$];
    int                 errors;

    function new();
      begin_code = BEGIN_CODE_RESET;
      end_code   = END_CODE_RESET;
      tok_count  = 0;
      rd_pos     = 0;
      errors     = 0;
    endfunction

    function void set_code(logic [CFG_IDX_W-1:0] idx, logic [TOKEN_W-1:0] code);
      if (idx == CFG_BEGIN_CODE) begin_code = code;
      else end_code = code;
    endfunction

    // pairs begins with ends, stops at the first overflow or stray end
    function logic [STATUS_W-1:0] pair_loops();
      int unsigned sp;
      int unsigned b;
      sp = 0;
      for (int unsigned i = 0; i < tok_count; i++) begin
        if (tok_mem[i] == begin_code) begin
          if (sp >= STACK_DEPTH) return STATUS_OVERFLOW;
          loop_stack[sp] = i;
          sp++;
        end else if (tok_mem[i] == end_code) begin
          if (sp == 0) return STATUS_UNMATCHED;
          sp--;
          b = loop_stack[sp];
          val_mem[b] = i + 1;
          val_mem[i] = b;
        end
      end
      return STATUS_OK;
    endfunction

    function void fetch_next(logic cond, inout rsp_t r);
      logic [TOKEN_W-1:0] t;
      longint unsigned    tgt;
      if (rd_pos >= tok_count) begin
        r.stream_end = 1'b1;
        return;
      end
      t = tok_mem[rd_pos];
      if (t == begin_code) begin
        if (cond) tgt = 64'(rd_pos) + 64'd1;
        else tgt = 64'(val_mem[rd_pos]);
      end else if (t == end_code) begin
        if (cond) tgt = 64'(val_mem[rd_pos]) + 64'd1;
        else tgt = 64'(rd_pos) + 64'd1;
      end else begin
        tgt = 64'(rd_pos);
      end
      // stale or unmatched jump targets end the stream
      if (tgt >= 64'(tok_count)) begin
        rd_pos = tok_count;
        r.stream_end = 1'b1;
        return;
      end
      rd_pos = 32'(tgt);
      r.token_out = tok_mem[rd_pos];
      r.value_out = val_mem[rd_pos];
      rd_pos++;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      e = '0;
      case (r.func)
        FUNC_APPEND: begin
          if (tok_count >= MAX_TOKENS) begin
            e.status = STATUS_FULL;
          end else begin
            tok_mem[tok_count] = r.token_code;
            val_mem[tok_count] = r.token_value;
            tok_count++;
          end
        end
        FUNC_MATCH: e.status = pair_loops();
        FUNC_FETCH: fetch_next(r.cond_valid, e);
        FUNC_REWIND: rd_pos = 0;
        FUNC_CLEAR: begin
          rd_pos = 0;
          tok_count = 0;
        end
        default: ;
      endcase
      results_due.push_back(e);
    endfunction

    function void mismatch(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: response with none expected, expected none, actual %h", $time, got);
        return;
      end
      want = results_due.pop_front();
      if (got.token_out !== want.token_out)
        mismatch("token_out", VALUE_W'(want.token_out), VALUE_W'(got.token_out));
      if (got.value_out !== want.value_out)
        mismatch("value_out", want.value_out, got.value_out);
      if (got.status !== want.status)
        mismatch("status", VALUE_W'(want.status), VALUE_W'(got.status));
      if (got.stream_end !== want.stream_end)
        mismatch("stream_end", VALUE_W'(want.stream_end), VALUE_W'(got.stream_end));
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req_data = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TOKEN_W-1:0]   cfg_data = '0;

  loop_sequencer_board board = new();
  int requests_sent = 0;
  bit sender_quiet = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;

  loop_token_sequencer_core #(
    .MAX_TOKENS (MAX_TOKENS),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_response(rsp_data);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // response side: random stalls, quiet stretches, and one long hold on demand
  initial begin
    int stall_left;
    int quiet_left;
    stall_left = 0;
    quiet_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0) begin
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(50, 150);
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic req_t rnd_req(logic [FUNC_W-1:0] f);
    req_t r;
    r.func        = f;
    r.token_code  = TOKEN_W'($urandom_range(0, 255));
    r.token_value = $urandom;
    r.cond_valid  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(int n);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return $urandom_range(0, n + 2);
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  function automatic logic [TOKEN_W-1:0] pick_code(inout int open, input int depth);
    int r;
    logic [TOKEN_W-1:0] c;
    r = $urandom_range(0, 9);
    if (r < 3 && open < depth) begin
      open++;
      return board.begin_code;
    end
    if (r < 5 && open > 0) begin
      open--;
      return board.end_code;
    end
    do c = TOKEN_W'($urandom_range(0, 255));
    while (c == board.begin_code || c == board.end_code);
    return c;
  endfunction

  task automatic issue(input req_t r);
    @(negedge clk);
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(r);
    if (r.func <= FUNC_CLEAR) requests_sent++;
    repeat (sender_quiet ? 0 : pick_gap()) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  task automatic append_token(input logic [TOKEN_W-1:0] c, input logic [VALUE_W-1:0] v);
    req_t r;
    r = rnd_req(FUNC_APPEND);
    r.token_code  = c;
    r.token_value = v;
    issue(r);
  endtask

  task automatic fetch_token(input logic cond);
    req_t r;
    r = rnd_req(FUNC_FETCH);
    r.cond_valid = cond;
    issue(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOKEN_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_code(idx, v);
  endtask

  // one program: build it, mostly pair the loops, then walk it with random conditions
  task automatic run_program(input int n);
    int open;
    int depth;
    int nf;
    int r;
    bit broken;
    open = 0;
    depth = $urandom_range(1, 6);
    broken = ($urandom_range(0, 6) == 0);
    sender_quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) != 0) issue(rnd_req(FUNC_CLEAR));
    for (int i = 0; i < n; i++) append_token(pick_code(open, depth), pick_value(n));
    if (!broken) begin
      while (open > 0) begin
        append_token(board.end_code, pick_value(n));
        open--;
      end
    end else if ($urandom_range(0, 1) == 0) begin
      append_token(board.end_code, pick_value(n));
    end
    if ($urandom_range(0, 9) != 0) issue(rnd_req(FUNC_MATCH));
    nf = $urandom_range(n, 3 * n + 4);
    for (int k = 0; k < nf; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) issue(rnd_req(FUNC_REWIND));
      else if (r < 6) issue(rnd_req(FUNC_W'(FUNC_FIRST_UNUSED + $urandom_range(0, 2))));
      else if (r < 8) issue(rnd_req(FUNC_APPEND));
      else if (r < 9) issue(rnd_req(FUNC_MATCH));
      else fetch_token(1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int goal;
    int open;
    logic [TOKEN_W-1:0] bc;
    logic [TOKEN_W-1:0] ec;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty stream, spare codes, stale jumps, loops both ways, stray end
    fetch_token(1'b1);
    for (int k = 0; k < 3; k++) issue(rnd_req(FUNC_W'(FUNC_FIRST_UNUSED + k)));
    append_token(8'd3, 32'h7fff_ffff);
    append_token(BEGIN_CODE_RESET, 32'h8000_0000);
    append_token(8'd255, 32'h0000_0000);
    append_token(END_CODE_RESET, 32'd5);
    append_token(8'd0, 32'hffff_ffff);
    fetch_token(1'b1);
    fetch_token(1'b0);
    fetch_token(1'b1);
    issue(rnd_req(FUNC_REWIND));
    issue(rnd_req(FUNC_MATCH));
    fetch_token(1'b0);
    fetch_token(1'b0);
    fetch_token(1'b1);
    issue(rnd_req(FUNC_REWIND));
    fetch_token(1'b1);
    fetch_token(1'b1);
    fetch_token(1'b1);
    fetch_token(1'b0);
    append_token(END_CODE_RESET, 32'd0);
    issue(rnd_req(FUNC_MATCH));
    issue(rnd_req(FUNC_CLEAR));
    fetch_token(1'b0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: begin
          bc = BEGIN_CODE_RESET;
          ec = END_CODE_RESET;
        end
        1: begin
          bc = 8'd0;
          ec = 8'd255;
        end
        2: begin
          bc = 8'd255;
          ec = 8'd0;
        end
        3: begin
          bc = TOKEN_W'($urandom_range(0, 255));
          ec = bc;
        end
        default: begin
          bc = TOKEN_W'($urandom_range(0, 255));
          do ec = TOKEN_W'($urandom_range(0, 255));
          while (ec == bc);
        end
      endcase
      write_reg(CFG_BEGIN_CODE, bc);
      write_reg(CFG_END_CODE, ec);

      if (p == 0) begin
        // nesting deeper than the stack
        sender_quiet = 1'b0;
        issue(rnd_req(FUNC_CLEAR));
        for (int i = 0; i < STACK_DEPTH + 2; i++) append_token(bc, $urandom);
        append_token(ec, $urandom);
        append_token(ec, $urandom);
        issue(rnd_req(FUNC_MATCH));
        for (int i = 0; i < 10; i++) fetch_token(1'($urandom_range(0, 1)));
      end
      if (p == 1) begin
        // fill the table, then overrun it
        sender_quiet = 1'b1;
        open = 0;
        issue(rnd_req(FUNC_CLEAR));
        for (int i = 0; i < MAX_TOKENS + 3; i++) append_token(pick_code(open, 8), $urandom);
        issue(rnd_req(FUNC_MATCH));
        for (int i = 0; i < 20; i++) fetch_token(1'($urandom_range(0, 1)));
        issue(rnd_req(FUNC_REWIND));
        for (int i = 0; i < 10; i++) fetch_token(1'($urandom_range(0, 1)));
      end
      if (p == 2) hold_req++;

      // the table fill already carries most of the traffic
      goal = requests_sent + ((p == 1) ? 0 : 15);
      while (requests_sent < goal) begin
        if ($urandom_range(0, 9) == 0) run_program($urandom_range(25, 50));
        else run_program($urandom_range(1, 12));
        if (p == 4 && $urandom_range(0, 2) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
